// ===== hw/rtl/tcbs_pkg.sv =====
// tcbs_pkg: types, sizes and address folding for the three-channel bit serializer
// used by every module of the serializer; depends on nothing else
package tcbs_pkg;

   localparam int WORD_BITS     = 16;
   localparam int STORE_DEPTH   = 256;
   localparam int CHANNEL_COUNT = 3;

   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int POS_W    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int ADDR_IN_W = 8;
   localparam int ADDR_IN_N = 1 << ADDR_IN_W;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_REQUEST = 2'd1,
      MODE_LOAD    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type        mode;
      logic [1:0]      channel;
      logic [7:0]      word_address;
      logic [15:0]     word_data;
      logic [2:0]      fifo_full;
   } req_type;

   typedef struct packed {
      logic [1:0]      fifo_select;
      logic            bit_out;
      logic            bit_valid;
      logic            word_done;
      logic            accepted;
   } rsp_type;

   // what the scheduler hands to the store and to the result pipeline
   typedef struct packed {
      logic                 rd_en;
      logic [STORE_AW-1:0]  rd_addr;
      logic                 wr_en;
      logic [STORE_AW-1:0]  wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic [1:0]           sel;
      logic [POS_W-1:0]     pos;
      logic                 bit_valid;
      logic                 word_done;
      logic                 accepted;
   } issue_type;

   typedef logic [STORE_AW-1:0] index_table_type [ADDR_IN_N];

   // folds an 8-bit address onto the store depth, built at elaboration
   function automatic index_table_type make_index_table();
      index_table_type t;
      for (int i = 0; i < ADDR_IN_N; i++) begin
         t[i] = STORE_AW'(i % STORE_DEPTH);
      end
      return t;
   endfunction

   localparam index_table_type INDEX_TABLE = make_index_table();

endpackage

// ===== hw/rtl/tcbs_store.sv =====
// tcbs_store: word store, one write port and one registered read port
// depends on tcbs_pkg; a same-cycle read and write of one entry returns the old word
module tcbs_store
   import tcbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [STORE_AW-1:0]  rd_addr,
   input  logic                 wr_en,
   input  logic [STORE_AW-1:0]  wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [STORE_DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcbs_sched.sv =====
// tcbs_sched: per-channel pending, address and bit count, fixed-priority pick
// depends on tcbs_pkg; drives the store ports and the result metadata
module tcbs_sched
   import tcbs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   output issue_type issue
);

   logic [CHANNEL_COUNT-1:0] pending_ff, pending_in;
   logic [STORE_AW-1:0]      addr_ff  [CHANNEL_COUNT];
   logic [STORE_AW-1:0]      addr_in  [CHANNEL_COUNT];
   logic [POS_W-1:0]         count_ff [CHANNEL_COUNT];
   logic [POS_W-1:0]         count_in [CHANNEL_COUNT];

   logic [CHANNEL_COUNT-1:0] full_vec;
   logic                     hit;
   logic [CH_W-1:0]          win;
   logic [POS_W-1:0]         pos;
   logic                     last;
   logic                     chan_ok;
   logic                     req_ok;
   logic [CH_W-1:0]          req_ch;
   logic                     is_tick;
   logic                     is_req;
   logic                     is_load;

   // channels without a full flag count as never full
   assign full_vec = CHANNEL_COUNT'(req.fifo_full);
   assign req_ch   = CH_W'(req.channel);
   assign chan_ok  = int'(req.channel) < CHANNEL_COUNT;

   always_comb begin
      is_tick = 1'b0;
      is_req  = 1'b0;
      is_load = 1'b0;
      unique case (req.mode)
         MODE_TICK:    is_tick = 1'b1;
         MODE_REQUEST: is_req  = 1'b1;
         MODE_LOAD:    is_load = 1'b1;
         default: ;
      endcase
   end

   // descending scan leaves the lowest eligible channel
   always_comb begin
      hit = 1'b0;
      win = '0;
      for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
         if (pending_ff[i] && !full_vec[i]) begin
            hit = 1'b1;
            win = CH_W'(i);
         end
      end
   end

   assign pos    = count_ff[win];
   assign last   = pos == POS_W'(WORD_BITS - 1);
   assign req_ok = chan_ok && !pending_ff[req_ch];

   always_comb begin
      pending_in = pending_ff;
      addr_in    = addr_ff;
      count_in   = count_ff;
      if (accept && is_req && req_ok) begin
         pending_in[req_ch] = 1'b1;
         addr_in[req_ch]    = INDEX_TABLE[req.word_address];
      end
      if (accept && is_tick && hit) begin
         if (last) begin
            pending_in[win] = 1'b0;
            count_in[win]   = '0;
         end else begin
            count_in[win] = pos + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            addr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         addr_ff    <= addr_in;
         count_ff   <= count_in;
      end
   end

   always_comb begin
      issue.rd_en     = accept && is_tick && hit;
      issue.rd_addr   = addr_ff[win];
      issue.wr_en     = accept && (is_load || (is_tick && hit && last));
      issue.wr_addr   = is_load ? INDEX_TABLE[req.word_address] : addr_ff[win];
      issue.wr_data   = is_load ? WORD_BITS'(req.word_data) : '0;
      issue.sel       = (is_tick && hit) ? 2'(int'(win) + 1) : 2'd0;
      issue.pos       = pos;
      issue.bit_valid = is_tick && hit;
      issue.word_done = is_tick && hit && last;
      issue.accepted  = is_req && req_ok;
   end

   // a finishing tick frees its channel
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      issue.rd_en && issue.word_done |=> !pending_ff[$past(win)])
      else $error("finished channel still pending");

   // the word clear always targets the word being read
   a_clear_same_entry: assert property (@(posedge clock) disable iff (reset)
      issue.rd_en && issue.wr_en |-> issue.wr_addr == issue.rd_addr)
      else $error("word clear hits another entry");

endmodule

// ===== hw/rtl/three_channel_bit_serializer_core.sv =====
// three_channel_bit_serializer_core: top level of the word-store bit serializer
// depends on tcbs_pkg, tcbs_store and tcbs_sched
//
// usage:
//   req_* carries one item per accepted cycle: a load writes a store word,
//   a request claims a channel for a store address, a tick with the full
//   flags lets the lowest pending channel that is not full send one bit,
//   lsb first. the word is zeroed after its last bit and the channel freed.
//   rsp_* returns exactly one item for every accepted req item, in order.
//   an accepted item goes through the store read, then the output register,
//   to rsp_valid. one item per cycle unless rsp stalls; the store read and the
//   word clear share one cycle of the memory, so ticks run back to back.
//   channel state updates at accept, so the next item sees it at once.
//   reset: synchronous; all channels idle, bit counts and addresses zero,
//   pipeline empty. the store is not cleared; load a word before sending it.
//   when the receiver stalls, the output register holds, one more item can
//   enter the read stage, and then req_stall rises until rsp moves again.
module three_channel_bit_serializer_core
   import tcbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   issue_type            issue;
   logic [WORD_BITS-1:0] rd_data;
   logic                 accept;
   logic                 out_free;

   logic                 s1_vld_ff, s1_vld_in;
   issue_type            s1_meta_ff, s1_meta_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   tcbs_sched u_sched (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .issue  (issue)
   );

   tcbs_store u_store (
      .clock   (clock),
      .rd_en   (issue.rd_en),
      .rd_addr (issue.rd_addr),
      .wr_en   (issue.wr_en),
      .wr_addr (issue.wr_addr),
      .wr_data (issue.wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      s1_meta_in = s1_meta_ff;
      if (accept) begin
         s1_vld_in  = 1'b1;
         s1_meta_in = issue;
      end else if (out_free) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in            = s1_vld_ff;
         rsp_data_in.fifo_select = s1_meta_ff.sel;
         rsp_data_in.bit_out     = s1_meta_ff.bit_valid && rd_data[s1_meta_ff.pos];
         rsp_data_in.bit_valid   = s1_meta_ff.bit_valid;
         rsp_data_in.word_done   = s1_meta_ff.word_done;
         rsp_data_in.accepted    = s1_meta_ff.accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_meta_ff  <= s1_meta_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a waiting read-stage item keeps its metadata
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !out_free |=> s1_vld_ff && $stable(s1_meta_ff))
      else $error("read stage lost a waiting item");

   // a served tick names a channel and never reports a request
   a_bit_has_select: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bit_valid |->
         rsp_data_ff.fifo_select != 2'd0 && !rsp_data_ff.accepted)
      else $error("bit without a channel");

   // an item in the read stage reaches the output once it is free
   a_s1_advances: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && out_free |=> rsp_valid_ff)
      else $error("read stage item dropped");

endmodule

// ===== dv/three_channel_bit_serializer_core_test.sv =====
// testbench for three_channel_bit_serializer_core: directed table, then random items
// in idling phases, each result checked against its typed row or the in-bench serializer predictor
// depends on tcbs_pkg and the core rtl
`timescale 1ns / 1ps

module three_channel_bit_serializer_core_test;
   import tcbs_pkg::*;

   localparam mode_type MODE_UNUSED  = mode_type'(2'd3);
   localparam int ITEMS_PER_PHASE    = 110;
   localparam int HOLD_CYCLES        = 60;
   localparam int DRAIN_CYCLES       = 8;
   localparam int CYCLE_LIMIT        = 200000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // serializer state as the predictor sees it
   bit                   chan_busy [CHANNEL_COUNT];
   logic [7:0]           chan_addr [CHANNEL_COUNT];
   int                   chan_pos  [CHANNEL_COUNT];
   logic [WORD_BITS-1:0] store_word [STORE_DEPTH];
   bit                   store_loaded [STORE_DEPTH];
   logic [7:0]           loaded_addrs [$];

   rsp_type      rsp_due [$];
   stim_row_type directed [$];
   rsp_type      rsp_head;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   int mismatches = 0;
   int rsp_seen = 0;
   int cycle_count = 0;
   int input_stall_cycles = 0;
   int bits_sent = 0;
   int words_sent = 0;
   int requests_taken = 0;
   int requests_refused = 0;
   int loads_done = 0;

   three_channel_bit_serializer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  rsp_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic rsp_type serialize_step(req_type r);
      rsp_type o;
      int      ch;
      int      a;
      o  = '0;
      ch = -1;
      case (r.mode)
         MODE_LOAD: begin
            store_word[r.word_address] = r.word_data;
            if (!store_loaded[r.word_address]) begin
               store_loaded[r.word_address] = 1'b1;
               loaded_addrs.push_back(r.word_address);
            end
            loads_done++;
         end
         MODE_REQUEST: begin
            if (r.channel < CHANNEL_COUNT && !chan_busy[r.channel]) begin
               chan_busy[r.channel] = 1'b1;
               chan_addr[r.channel] = r.word_address;
               o.accepted = 1'b1;
               requests_taken++;
            end else begin
               requests_refused++;
            end
         end
         MODE_TICK: begin
            for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
               if (chan_busy[i] && !r.fifo_full[i]) ch = i;
            end
            if (ch >= 0) begin
               a = chan_addr[ch];
               o.fifo_select = 2'(ch + 1);
               o.bit_out     = store_word[a][chan_pos[ch]];
               o.bit_valid   = 1'b1;
               bits_sent++;
               chan_pos[ch]++;
               if (chan_pos[ch] >= WORD_BITS) begin
                  store_word[a] = '0;
                  chan_pos[ch]  = 0;
                  chan_busy[ch] = 1'b0;
                  o.word_done   = 1'b1;
                  words_sent++;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(mode_type m, int ch, int addr, int data, int full);
      req_type r;
      r.mode         = m;
      r.channel      = 2'(ch);
      r.word_address = 8'(addr);
      r.word_data    = 16'(data);
      r.fifo_full    = 3'(full);
      return r;
   endfunction

   // well-formed traffic mostly; a request that could be taken only names a loaded word
   function automatic req_type make_random_item();
      req_type r;
      int      pick;
      r.channel      = 2'($urandom_range(0, 3));
      r.word_address = 8'($urandom);
      r.word_data    = 16'($urandom);
      r.fifo_full    = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.mode = MODE_TICK;
         if ($urandom_range(0, 99) < 60) r.fifo_full = '0;
      end else if (pick < 73) begin
         r.mode = MODE_REQUEST;
         r.channel = ($urandom_range(0, 9) == 0) ? 2'(CHANNEL_COUNT)
                                                  : 2'($urandom_range(0, CHANNEL_COUNT - 1));
         if (r.channel < CHANNEL_COUNT && !chan_busy[r.channel])
            r.word_address = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
      end else if (pick < 95) begin
         r.mode = MODE_LOAD;
      end else begin
         r.mode = MODE_UNUSED;
      end
      return r;
   endfunction

   task automatic drive_item(req_type r, bit typed, rsp_type want);
      rsp_type p;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = serialize_step(r);
      rsp_due.push_back(typed ? want : p);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on result %0d: %s got %0h want %0h", rsp_seen, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               report_mismatch("item with nothing due", rsp_data, 0);
            end else begin
               rsp_head = rsp_due.pop_front();
               if (rsp_data.fifo_select !== rsp_head.fifo_select)
                  report_mismatch("fifo_select", rsp_data.fifo_select, rsp_head.fifo_select);
               if (rsp_data.bit_out !== rsp_head.bit_out)
                  report_mismatch("bit_out", rsp_data.bit_out, rsp_head.bit_out);
               if (rsp_data.bit_valid !== rsp_head.bit_valid)
                  report_mismatch("bit_valid", rsp_data.bit_valid, rsp_head.bit_valid);
               if (rsp_data.word_done !== rsp_head.word_done)
                  report_mismatch("word_done", rsp_data.word_done, rsp_head.word_done);
               if (rsp_data.accepted !== rsp_head.accepted)
                  report_mismatch("accepted", rsp_data.accepted, rsp_head.accepted);
            end
            rsp_seen++;
         end
      end
   end

   initial begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         chan_busy[i] = 1'b0;
         chan_addr[i] = '0;
         chan_pos[i]  = 0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_word[i]   = '0;
         store_loaded[i] = 1'b0;
      end

      // typed rows are plain enough to read off by eye; the rest use the predictor
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 0), 1, '0});
      directed.push_back('{make_req(MODE_UNUSED, 3, 'hFF, 'hFFFF, 7), 1, '0});
      directed.push_back('{make_req(MODE_LOAD, 0, 'hFF, 'hFFFF, 0), 1, '0});
      directed.push_back('{make_req(MODE_LOAD, 0, 'h00, 'hA5A5, 0), 1, '0});
      directed.push_back('{make_req(MODE_LOAD, 0, 'h5A, 'h0001, 0), 1, '0});
      directed.push_back('{make_req(MODE_REQUEST, CHANNEL_COUNT, 'h00, 0, 0), 1, '0});
      directed.push_back('{make_req(MODE_REQUEST, 0, 'hFF, 0, 0), 1,
                           rsp_type'{2'd0, 1'b0, 1'b0, 1'b0, 1'b1}});
      directed.push_back('{make_req(MODE_REQUEST, 0, 'h00, 0, 0), 1, '0});
      directed.push_back('{make_req(MODE_REQUEST, 1, 'h00, 0, 0), 1,
                           rsp_type'{2'd0, 1'b0, 1'b0, 1'b0, 1'b1}});
      directed.push_back('{make_req(MODE_REQUEST, 2, 'h5A, 0, 0), 1,
                           rsp_type'{2'd0, 1'b0, 1'b0, 1'b0, 1'b1}});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 7), 1, '0});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 0), 1,
                           rsp_type'{2'd1, 1'b1, 1'b1, 1'b0, 1'b0}});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 1), 1,
                           rsp_type'{2'd2, 1'b1, 1'b1, 1'b0, 1'b0}});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 3), 1,
                           rsp_type'{2'd3, 1'b1, 1'b1, 1'b0, 1'b0}});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 3), 0, '0});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 6), 0, '0});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 5), 0, '0});
      // overwrite a word that a channel is partway through
      directed.push_back('{make_req(MODE_LOAD, 0, 'h00, 'h0000, 0), 1, '0});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 1), 0, '0});
      directed.push_back('{make_req(MODE_REQUEST, 1, 'h5A, 0, 0), 1, '0});
      directed.push_back('{make_req(MODE_TICK, 0, 0, 0, 0), 0, '0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) drive_item(directed[i].item, directed[i].typed, directed[i].want);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 52; end
            3: begin sender_idle_pct = 35; rsp_stall_pct = 35; end
            default: begin
               // receiver holds off long enough for the core to back up its input
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
               hold_token++;
            end
         endcase
         repeat (ITEMS_PER_PHASE) drive_item(make_random_item(), 0, '0);
      end
      req_valid <= 1'b0;

      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads, %0d requests taken, %0d refused, %0d bits, %0d words",
               loads_done, requests_taken, requests_refused, bits_sent, words_sent);
      $display("%0d results checked, input held back for %0d cycles",
               rsp_seen, input_stall_cycles);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tcbs_pkg.sv
hw/rtl/tcbs_store.sv
hw/rtl/tcbs_sched.sv
hw/rtl/three_channel_bit_serializer_core.sv
dv/three_channel_bit_serializer_core_test.sv
